@@ hw/rtl/mcfc_pkg.sv @@
// ----------------------------------------------------------------------------
// mcfc_pkg
// Shared types and constants of the meter calibration frame checker.
// ----------------------------------------------------------------------------
package mcfc_pkg;

  localparam int PAYLOAD_BYTES_DEFAULT = 72;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 48;

  localparam logic [CFG_INDEX_W-1:0] REG_STATION_ADDRESS = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_START_MARKER    = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_END_MARKER      = 2'd2;

  localparam logic [47:0] STATION_ADDRESS_RESET = 48'd18764998447377;
  localparam logic [7:0]  START_MARKER_RESET    = 8'h68;
  localparam logic [7:0]  END_MARKER_RESET      = 8'h16;

  localparam logic [1:0] VERDICT_READ        = 2'd0;
  localparam logic [1:0] VERDICT_WRITE_OK    = 2'd1;
  localparam logic [1:0] VERDICT_PAYLOAD_BAD = 2'd2;
  localparam logic [1:0] VERDICT_FRAME_ERROR = 2'd3;

  localparam logic [7:0]  CTRL_READ       = 8'h11;
  localparam logic [7:0]  LEN_READ        = 8'h04;
  localparam logic [7:0]  CTRL_WRITE      = 8'h14;
  localparam int          LEN_WRITE_BASE  = 'h0C;
  localparam logic [7:0]  PAYLOAD_BIAS    = 8'h33;
  localparam logic [15:0] WORD_LIMIT      = 16'h8000;

  localparam int READ_LEN       = 19;
  localparam int WRITE_OVERHEAD = 24;
  localparam int PAYLOAD_START  = 22;

  localparam logic [7:0] OFF_W0_LO = 8'd4;
  localparam logic [7:0] OFF_W0_HI = 8'd5;
  localparam logic [7:0] OFF_W1_LO = 8'd10;
  localparam logic [7:0] OFF_W1_HI = 8'd11;
  localparam logic [7:0] OFF_W2_LO = 8'd12;
  localparam logic [7:0] OFF_W2_HI = 8'd13;
  localparam logic [7:0] OFF_W3_LO = 8'd30;
  localparam logic [7:0] OFF_W3_HI = 8'd31;

  typedef struct packed {
    logic [47:0] station_address;
    logic [7:0]  start_marker;
    logic [7:0]  end_marker;
  } cfg_t;

  function automatic logic [7:0] addr_byte(input logic [47:0] addr, input logic [2:0] k);
    logic [7:0] b;
    b = 8'h00;
    unique case (k)
      3'd0: b = addr[7:0];
      3'd1: b = addr[15:8];
      3'd2: b = addr[23:16];
      3'd3: b = addr[31:24];
      3'd4: b = addr[39:32];
      3'd5: b = addr[47:40];
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

@@ hw/rtl/mcfc_track.sv @@
// ----------------------------------------------------------------------------
// mcfc_track
// Per-frame running state: position, sums, layout and payload checks, verdict.
// ----------------------------------------------------------------------------
module mcfc_track #(
  parameter int PAYLOAD_BYTES = mcfc_pkg::PAYLOAD_BYTES_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [7:0]        rx_byte,
  input  logic              frame_end,
  input  mcfc_pkg::cfg_t    cfg,
  output logic [1:0]        verdict
);

  localparam int WRITE_LEN = mcfc_pkg::WRITE_OVERHEAD + PAYLOAD_BYTES;
  localparam logic [7:0] READ_LAST  = 8'(mcfc_pkg::READ_LEN - 1);
  localparam logic [7:0] WRITE_LAST = 8'(WRITE_LEN - 1);
  localparam logic [7:0] LEN_WRITE  = 8'(mcfc_pkg::LEN_WRITE_BASE + PAYLOAD_BYTES);
  localparam logic [7:0] PL_START   = 8'(mcfc_pkg::PAYLOAD_START);
  localparam logic [7:0] PL_BYTES   = 8'(PAYLOAD_BYTES);

  logic [7:0] byte_position, byte_position_next;
  logic [7:0] sum_all, sum_all_next;
  logic [7:0] sum_after_lead, sum_after_lead_next;
  logic [7:0] back_one, back_one_next;
  logic       short_layout_ok, short_layout_ok_next;
  logic       long_layout_ok, long_layout_ok_next;
  logic       payload_ok, payload_ok_next;
  logic [7:0] held_low_byte, held_low_byte_next;

  logic [7:0]  offset;
  logic [7:0]  unbiased;
  logic [15:0] word;
  logic        in_payload;
  logic        sum_ok_read;
  logic        sum_ok_write;

  assign offset     = byte_position - PL_START;
  assign unbiased   = rx_byte - mcfc_pkg::PAYLOAD_BIAS;
  assign word       = {unbiased, held_low_byte};
  assign in_payload = (byte_position >= PL_START) && (offset < PL_BYTES);

  assign sum_ok_read  = (8'(sum_after_lead - back_one) == back_one);
  assign sum_ok_write = (8'(sum_all - back_one) == back_one);

  always_comb begin
    verdict = mcfc_pkg::VERDICT_FRAME_ERROR;
    if (byte_position == READ_LAST) begin
      if (short_layout_ok && sum_ok_read && rx_byte == cfg.end_marker) begin
        verdict = mcfc_pkg::VERDICT_READ;
      end
    end else if (byte_position == WRITE_LAST) begin
      if (long_layout_ok && sum_ok_write && rx_byte == cfg.end_marker) begin
        verdict = payload_ok ? mcfc_pkg::VERDICT_WRITE_OK : mcfc_pkg::VERDICT_PAYLOAD_BAD;
      end
    end
  end

  always_comb begin
    byte_position_next   = byte_position;
    sum_all_next         = sum_all;
    sum_after_lead_next  = sum_after_lead;
    back_one_next        = back_one;
    short_layout_ok_next = short_layout_ok;
    long_layout_ok_next  = long_layout_ok;
    payload_ok_next      = payload_ok;
    held_low_byte_next   = held_low_byte;

    if (step) begin
      if (frame_end) begin
        byte_position_next   = 8'd0;
        sum_all_next         = 8'd0;
        sum_after_lead_next  = 8'd0;
        back_one_next        = 8'd0;
        short_layout_ok_next = 1'b1;
        long_layout_ok_next  = 1'b1;
        payload_ok_next      = 1'b1;
        held_low_byte_next   = 8'd0;
      end else begin
        if (byte_position == 8'd3 || byte_position == 8'd10) begin
          if (rx_byte != cfg.start_marker) short_layout_ok_next = 1'b0;
        end else if (byte_position >= 8'd4 && byte_position <= 8'd9) begin
          if (rx_byte != mcfc_pkg::addr_byte(cfg.station_address, 3'(byte_position - 8'd4))) begin
            short_layout_ok_next = 1'b0;
          end
        end else if (byte_position == 8'd11) begin
          if (rx_byte != mcfc_pkg::CTRL_READ) short_layout_ok_next = 1'b0;
        end else if (byte_position == 8'd12) begin
          if (rx_byte != mcfc_pkg::LEN_READ) short_layout_ok_next = 1'b0;
        end

        if (byte_position == 8'd0 || byte_position == 8'd7) begin
          if (rx_byte != cfg.start_marker) long_layout_ok_next = 1'b0;
        end else if (byte_position >= 8'd1 && byte_position <= 8'd6) begin
          if (rx_byte != mcfc_pkg::addr_byte(cfg.station_address, 3'(byte_position - 8'd1))) begin
            long_layout_ok_next = 1'b0;
          end
        end else if (byte_position == 8'd8) begin
          if (rx_byte != mcfc_pkg::CTRL_WRITE) long_layout_ok_next = 1'b0;
        end else if (byte_position == 8'd9) begin
          if (rx_byte != LEN_WRITE) long_layout_ok_next = 1'b0;
        end else if (in_payload) begin
          if (offset == mcfc_pkg::OFF_W0_LO || offset == mcfc_pkg::OFF_W1_LO ||
              offset == mcfc_pkg::OFF_W2_LO || offset == mcfc_pkg::OFF_W3_LO) begin
            held_low_byte_next = unbiased;
          end else if (offset == mcfc_pkg::OFF_W0_HI) begin
            if (word == 16'h0000) payload_ok_next = 1'b0;
          end else if (offset == mcfc_pkg::OFF_W1_HI || offset == mcfc_pkg::OFF_W2_HI ||
                       offset == mcfc_pkg::OFF_W3_HI) begin
            if (word == mcfc_pkg::WORD_LIMIT) payload_ok_next = 1'b0;
          end
        end

        sum_all_next = sum_all + rx_byte;
        if (byte_position >= 8'd3) sum_after_lead_next = sum_after_lead + rx_byte;
        back_one_next = rx_byte;
        if (byte_position != 8'hFF) byte_position_next = byte_position + 8'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position   <= 8'd0;
      sum_all         <= 8'd0;
      sum_after_lead  <= 8'd0;
      back_one        <= 8'd0;
      short_layout_ok <= 1'b1;
      long_layout_ok  <= 1'b1;
      payload_ok      <= 1'b1;
      held_low_byte   <= 8'd0;
    end else begin
      byte_position   <= byte_position_next;
      sum_all         <= sum_all_next;
      sum_after_lead  <= sum_after_lead_next;
      back_one        <= back_one_next;
      short_layout_ok <= short_layout_ok_next;
      long_layout_ok  <= long_layout_ok_next;
      payload_ok      <= payload_ok_next;
      held_low_byte   <= held_low_byte_next;
    end
  end

endmodule

@@ hw/rtl/meter_calibration_frame_check.sv @@
// ----------------------------------------------------------------------------
// meter_calibration_frame_check
// Byte stream frame checker with one verdict request per frame.
// ----------------------------------------------------------------------------
// Takes one frame byte per clock on the slave stream, tlast on the final byte,
// and issues one verdict request on the master stream for each frame: 0 read
// request, 1 valid write, 2 payload invalid, 3 frame error. A byte passes an
// input register, then the running checks, then the result register, which
// takes the verdict when the final byte leaves the checks; a new byte can be
// taken every clock while the result register is free or being emptied.
// Configuration writes belong between frames.
// ----------------------------------------------------------------------------
module meter_calibration_frame_check #(
  parameter int PAYLOAD_BYTES = mcfc_pkg::PAYLOAD_BYTES_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [7:0]                       s_tdata,   // [7:0] rx_byte
  input  logic                             s_tlast,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [7:0]                       m_tdata,   // [1:0] verdict, [7:2] zero
  input  logic                             cfg_we,
  input  logic [mcfc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [mcfc_pkg::CFG_DATA_W-1:0]  cfg_data
);

  mcfc_pkg::cfg_t cfg;

  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_last;
  logic       advance;
  logic       step;
  logic [1:0] verdict_comb;
  logic [1:0] verdict;

  assign advance  = !m_tvalid || m_tready;
  assign s_tready = !in_valid || advance;
  assign step     = in_valid && advance;
  assign m_tdata  = {6'd0, verdict};

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.station_address <= mcfc_pkg::STATION_ADDRESS_RESET;
      cfg.start_marker    <= mcfc_pkg::START_MARKER_RESET;
      cfg.end_marker      <= mcfc_pkg::END_MARKER_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mcfc_pkg::REG_STATION_ADDRESS: cfg.station_address <= cfg_data[47:0];
        mcfc_pkg::REG_START_MARKER:    cfg.start_marker    <= cfg_data[7:0];
        mcfc_pkg::REG_END_MARKER:      cfg.end_marker      <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
      in_last <= s_tlast;
    end
  end

  mcfc_track #(
    .PAYLOAD_BYTES(PAYLOAD_BYTES)
  ) u_track (
    .clk      (clk),
    .rst      (rst),
    .step     (step),
    .rx_byte  (in_byte),
    .frame_end(in_last),
    .cfg      (cfg),
    .verdict  (verdict_comb)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= in_valid && in_last;
    end
  end

  always_ff @(posedge clk) begin
    if (step && in_last) begin
      verdict <= verdict_comb;
    end
  end

endmodule

@@ tb/sv/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the meter calibration frame checker.
// ----------------------------------------------------------------------------
// Builds read and write frames byte by byte, some intact and some spoilt, plus
// noise frames of odd and overlong size, and sends them on the slave stream
// with random gaps. A model of the frame checks inside the bench predicts one
// verdict per frame end; each verdict request on the master stream is checked
// against the oldest prediction. The station address and both markers are
// rewritten between traffic phases, extremes included, and the receiver
// stalls at random and once for a long stretch so that the block backs up.
// ----------------------------------------------------------------------------
module tb;

  localparam int PAYLOAD_BYTES = mcfc_pkg::PAYLOAD_BYTES_DEFAULT;
  localparam int WRITE_LEN = mcfc_pkg::WRITE_OVERHEAD + PAYLOAD_BYTES;
  localparam logic [mcfc_pkg::CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 800000;
  localparam int unsigned CHOKE_CYCLES = 400;
  localparam int unsigned SETTLE_CYCLES = 6;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [7:0] s_tdata = 8'h00;
  logic s_tlast = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [7:0] m_tdata;
  logic cfg_we = 1'b0;
  logic [mcfc_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [mcfc_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  logic [47:0] cal_addr = mcfc_pkg::STATION_ADDRESS_RESET;
  logic [7:0] sof_byte = mcfc_pkg::START_MARKER_RESET;
  logic [7:0] eof_byte = mcfc_pkg::END_MARKER_RESET;

  logic [7:0] pos_q = 8'd0;
  logic [7:0] sum_all_q = 8'd0;
  logic [7:0] sum_lead_q = 8'd0;
  logic [7:0] prev_q = 8'd0;
  logic [7:0] held_lo_q = 8'd0;
  bit read_ok_q = 1'b1;
  bit write_ok_q = 1'b1;
  bit payload_ok_q = 1'b1;

  logic [7:0] frame_bytes[$];
  logic [1:0] verdicts_due[$];
  logic [1:0] verdict_exp;

  bit tx_gaps = 1'b1;
  bit rx_stalls = 1'b0;
  bit choke_req = 1'b0;
  int unsigned rx_hold = 0;
  int unsigned rx_roll;
  int unsigned cycle_count = 0;
  int unsigned fail_count = 0;

  meter_calibration_frame_check #(
    .PAYLOAD_BYTES(PAYLOAD_BYTES)
  ) dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),   // [7:0] rx_byte
    .s_tlast(s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),   // [1:0] verdict, [7:2] zero
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  // receiver: random stalls, and one long hold-off on request
  always @(posedge clk) begin
    if (choke_req) begin
      choke_req <= 1'b0;
      rx_hold <= CHOKE_CYCLES;
      m_tready <= 1'b0;
    end else if (rx_hold != 0) begin
      rx_hold <= rx_hold - 1;
      m_tready <= 1'b0;
    end else if (!rx_stalls) begin
      m_tready <= 1'b1;
    end else begin
      rx_roll = $urandom_range(0, 99);
      if (rx_roll < 75) begin
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b0;
        rx_hold <= (rx_roll < 95) ? $urandom_range(0, 2) : $urandom_range(8, 40);
      end
    end
  end

  always @(posedge clk) begin
    if (m_tvalid && m_tready) begin
      if (verdicts_due.size() == 0) begin
        $error("verdict: expected none, actual %0d", m_tdata[1:0]);
        fail_count++;
      end else begin
        verdict_exp = verdicts_due.pop_front();
        if (m_tdata[1:0] !== verdict_exp) begin
          $error("verdict: expected %0d, actual %0d", verdict_exp, m_tdata[1:0]);
          fail_count++;
        end
        if (m_tdata[7:2] !== 6'd0) begin
          $error("pad: expected 0, actual %0h", m_tdata[7:2]);
          fail_count++;
        end
      end
    end
  end

  task automatic predict_verdict(input logic [7:0] b, input bit is_final);
    int unsigned p;
    int unsigned off;
    logic [7:0] plain;
    logic [15:0] payload_word;
    logic [1:0] verdict;
    p = pos_q;
    plain = b - mcfc_pkg::PAYLOAD_BIAS;
    payload_word = {plain, held_lo_q};
    if (p == 3 || p == 10) begin
      if (b != sof_byte) read_ok_q = 1'b0;
    end else if (p >= 4 && p <= 9) begin
      if (b != cal_addr[8*(p-4) +: 8]) read_ok_q = 1'b0;
    end else if (p == 11) begin
      if (b != mcfc_pkg::CTRL_READ) read_ok_q = 1'b0;
    end else if (p == 12) begin
      if (b != mcfc_pkg::LEN_READ) read_ok_q = 1'b0;
    end
    if (p == 0 || p == 7) begin
      if (b != sof_byte) write_ok_q = 1'b0;
    end else if (p >= 1 && p <= 6) begin
      if (b != cal_addr[8*(p-1) +: 8]) write_ok_q = 1'b0;
    end else if (p == 8) begin
      if (b != mcfc_pkg::CTRL_WRITE) write_ok_q = 1'b0;
    end else if (p == 9) begin
      if (b != 8'(mcfc_pkg::LEN_WRITE_BASE + PAYLOAD_BYTES)) write_ok_q = 1'b0;
    end else if (p >= mcfc_pkg::PAYLOAD_START &&
                 p < mcfc_pkg::PAYLOAD_START + PAYLOAD_BYTES) begin
      off = p - mcfc_pkg::PAYLOAD_START;
      if (off == mcfc_pkg::OFF_W0_LO || off == mcfc_pkg::OFF_W1_LO ||
          off == mcfc_pkg::OFF_W2_LO || off == mcfc_pkg::OFF_W3_LO) begin
        held_lo_q = plain;
      end else if (off == mcfc_pkg::OFF_W0_HI) begin
        if (payload_word == 16'h0000) payload_ok_q = 1'b0;
      end else if (off == mcfc_pkg::OFF_W1_HI || off == mcfc_pkg::OFF_W2_HI ||
                   off == mcfc_pkg::OFF_W3_HI) begin
        if (payload_word == mcfc_pkg::WORD_LIMIT) payload_ok_q = 1'b0;
      end
    end
    if (!is_final) begin
      sum_all_q = sum_all_q + b;
      if (p >= 3) sum_lead_q = sum_lead_q + b;
      prev_q = b;
      if (pos_q != 8'd255) pos_q = pos_q + 1;
    end else begin
      verdict = mcfc_pkg::VERDICT_FRAME_ERROR;
      if (p + 1 == mcfc_pkg::READ_LEN) begin
        if (read_ok_q && 8'(sum_lead_q - prev_q) == prev_q && b == eof_byte)
          verdict = mcfc_pkg::VERDICT_READ;
      end else if (p + 1 == WRITE_LEN) begin
        if (write_ok_q && 8'(sum_all_q - prev_q) == prev_q && b == eof_byte)
          verdict = payload_ok_q ? mcfc_pkg::VERDICT_WRITE_OK
                                 : mcfc_pkg::VERDICT_PAYLOAD_BAD;
      end
      verdicts_due.push_back(verdict);
      pos_q = 8'd0;
      sum_all_q = 8'd0;
      sum_lead_q = 8'd0;
      prev_q = 8'd0;
      held_lo_q = 8'd0;
      read_ok_q = 1'b1;
      write_ok_q = 1'b1;
      payload_ok_q = 1'b1;
    end
  endtask

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 65) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(6, 20);
  endfunction

  task automatic send_byte(input logic [7:0] b, input bit is_final);
    int unsigned gap;
    s_tvalid <= 1'b1;
    s_tdata <= b;
    s_tlast <= is_final;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_verdict(b, is_final);
    gap = tx_gaps ? pick_gap() : 0;
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_frame();
    foreach (frame_bytes[i]) send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
  endtask

  task automatic quiesce();
    s_tvalid <= 1'b0;
    while (verdicts_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [mcfc_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [47:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      mcfc_pkg::REG_STATION_ADDRESS: cal_addr = value;
      mcfc_pkg::REG_START_MARKER: sof_byte = value[7:0];
      mcfc_pkg::REG_END_MARKER: eof_byte = value[7:0];
      default: ;
    endcase
  endtask

  // checksum sits just before the end byte; reads skip the lead bytes
  task automatic fix_sum(input bit is_write);
    logic [7:0] acc;
    acc = 8'd0;
    for (int i = is_write ? 0 : 3; i < frame_bytes.size() - 2; i++) acc = acc + frame_bytes[i];
    frame_bytes[frame_bytes.size() - 2] = acc;
  endtask

  task automatic make_read_frame();
    frame_bytes.delete();
    repeat (3) frame_bytes.push_back(8'($urandom));
    frame_bytes.push_back(sof_byte);
    for (int k = 0; k < 6; k++) frame_bytes.push_back(cal_addr[8*k +: 8]);
    frame_bytes.push_back(sof_byte);
    frame_bytes.push_back(mcfc_pkg::CTRL_READ);
    frame_bytes.push_back(mcfc_pkg::LEN_READ);
    repeat (4) frame_bytes.push_back(8'($urandom));
    frame_bytes.push_back(8'h00);
    frame_bytes.push_back(eof_byte);
    fix_sum(1'b0);
  endtask

  task automatic make_write_frame();
    frame_bytes.delete();
    frame_bytes.push_back(sof_byte);
    for (int k = 0; k < 6; k++) frame_bytes.push_back(cal_addr[8*k +: 8]);
    frame_bytes.push_back(sof_byte);
    frame_bytes.push_back(mcfc_pkg::CTRL_WRITE);
    frame_bytes.push_back(8'(mcfc_pkg::LEN_WRITE_BASE + PAYLOAD_BYTES));
    repeat (mcfc_pkg::PAYLOAD_START - 10 + PAYLOAD_BYTES)
      frame_bytes.push_back(8'($urandom));
    frame_bytes.push_back(8'h00);
    frame_bytes.push_back(eof_byte);
    fix_sum(1'b1);
  endtask

  task automatic set_words(input logic [15:0] w0, input logic [15:0] w1,
                           input logic [15:0] w2, input logic [15:0] w3);
    frame_bytes[mcfc_pkg::PAYLOAD_START + mcfc_pkg::OFF_W0_LO] =
      w0[7:0] + mcfc_pkg::PAYLOAD_BIAS;
    frame_bytes[mcfc_pkg::PAYLOAD_START + mcfc_pkg::OFF_W0_HI] =
      w0[15:8] + mcfc_pkg::PAYLOAD_BIAS;
    frame_bytes[mcfc_pkg::PAYLOAD_START + mcfc_pkg::OFF_W1_LO] =
      w1[7:0] + mcfc_pkg::PAYLOAD_BIAS;
    frame_bytes[mcfc_pkg::PAYLOAD_START + mcfc_pkg::OFF_W1_HI] =
      w1[15:8] + mcfc_pkg::PAYLOAD_BIAS;
    frame_bytes[mcfc_pkg::PAYLOAD_START + mcfc_pkg::OFF_W2_LO] =
      w2[7:0] + mcfc_pkg::PAYLOAD_BIAS;
    frame_bytes[mcfc_pkg::PAYLOAD_START + mcfc_pkg::OFF_W2_HI] =
      w2[15:8] + mcfc_pkg::PAYLOAD_BIAS;
    frame_bytes[mcfc_pkg::PAYLOAD_START + mcfc_pkg::OFF_W3_LO] =
      w3[7:0] + mcfc_pkg::PAYLOAD_BIAS;
    frame_bytes[mcfc_pkg::PAYLOAD_START + mcfc_pkg::OFF_W3_HI] =
      w3[15:8] + mcfc_pkg::PAYLOAD_BIAS;
    fix_sum(1'b1);
  endtask

  task automatic send_words(input logic [15:0] w0, input logic [15:0] w1,
                            input logic [15:0] w2, input logic [15:0] w3, input bit bad_sum);
    make_write_frame();
    set_words(w0, w1, w2, w3);
    if (bad_sum) frame_bytes[WRITE_LEN - 2] ^= 8'h01;
    send_frame();
  endtask

  task automatic send_altered(input bit is_write, input int unsigned pos, input logic [7:0] mask);
    if (is_write) make_write_frame();
    else make_read_frame();
    frame_bytes[pos] ^= mask;
    if (pos != frame_bytes.size() - 2) fix_sum(is_write);
    send_frame();
  endtask

  function automatic logic [15:0] pick_word(input logic [15:0] trap);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 20) return trap;
    if (roll < 30) return trap ^ (16'h0001 << $urandom_range(0, 15));
    return 16'($urandom);
  endfunction

  task automatic spoil_frame(input bit is_write);
    int unsigned roll;
    int unsigned pos;
    roll = $urandom_range(0, 99);
    pos = $urandom_range(0, frame_bytes.size() - 1);
    if (roll < 25) begin
      frame_bytes[pos] ^= 8'($urandom_range(1, 255));
      if ($urandom_range(0, 1) == 1) fix_sum(is_write);
    end else if (roll < 29) begin
      frame_bytes.delete(pos);
    end else if (roll < 32) begin
      frame_bytes.insert(pos, 8'($urandom));
    end
  endtask

  task automatic make_noise_frame();
    int unsigned roll;
    int unsigned len;
    roll = $urandom_range(0, 99);
    if (roll < 10) len = mcfc_pkg::READ_LEN;
    else if (roll < 20) len = WRITE_LEN;
    else if (roll < 23) len = $urandom_range(200, 300);
    else len = $urandom_range(1, 24);
    frame_bytes.delete();
    repeat (len) frame_bytes.push_back(8'($urandom));
  endtask

  task automatic run_random(input int unsigned min_bytes, input int unsigned min_frames);
    int unsigned bytes_sent;
    int unsigned frames_sent;
    int unsigned roll;
    bytes_sent = 0;
    frames_sent = 0;
    while (bytes_sent < min_bytes || frames_sent < min_frames) begin
      tx_gaps = ($urandom_range(0, 3) != 0);
      rx_stalls <= ($urandom_range(0, 3) != 0);
      roll = $urandom_range(0, 99);
      if (roll < 40) begin
        make_read_frame();
        spoil_frame(1'b0);
      end else if (roll < 65) begin
        make_write_frame();
        set_words(pick_word(16'h0000), pick_word(mcfc_pkg::WORD_LIMIT),
                  pick_word(mcfc_pkg::WORD_LIMIT), pick_word(mcfc_pkg::WORD_LIMIT));
        spoil_frame(1'b1);
      end else begin
        make_noise_frame();
      end
      bytes_sent += frame_bytes.size();
      frames_sent++;
      send_frame();
    end
  endtask

  task automatic test_read_requests();
    make_read_frame();
    frame_bytes[0] = 8'h00;
    frame_bytes[1] = 8'hFF;
    frame_bytes[13] = 8'hFF;
    frame_bytes[14] = 8'h00;
    fix_sum(1'b0);
    send_frame();
    send_altered(1'b0, mcfc_pkg::READ_LEN - 2, 8'h01);
    send_altered(1'b0, mcfc_pkg::READ_LEN - 1, 8'h80);
    send_altered(1'b0, 11, mcfc_pkg::CTRL_READ ^ mcfc_pkg::CTRL_WRITE);
    send_altered(1'b0, 12, 8'h01);
    send_altered(1'b0, $urandom_range(4, 9), 8'h80);
    send_altered(1'b0, 3, 8'h01);
    send_altered(1'b0, 10, 8'h40);
  endtask

  task automatic test_write_frames();
    make_write_frame();
    frame_bytes[mcfc_pkg::PAYLOAD_START] = 8'h00;
    frame_bytes[mcfc_pkg::PAYLOAD_START + 1] = 8'hFF;
    set_words(16'h0001, 16'h8001, 16'h0080, 16'h7FFF);
    send_frame();
    send_words(16'h0000, 16'h1234, 16'h1234, 16'h1234, 1'b0);
    send_words(16'h0100, mcfc_pkg::WORD_LIMIT, 16'h1234, 16'h1234, 1'b0);
    send_words(16'h0100, 16'h1234, mcfc_pkg::WORD_LIMIT, 16'h1234, 1'b0);
    send_words(16'h0100, 16'h1234, 16'h1234, mcfc_pkg::WORD_LIMIT, 1'b0);
    send_words(16'h0000, mcfc_pkg::WORD_LIMIT, mcfc_pkg::WORD_LIMIT,
               mcfc_pkg::WORD_LIMIT, 1'b1);
    send_altered(1'b1, 0, 8'h01);
    send_altered(1'b1, $urandom_range(1, 6), 8'h02);
    send_altered(1'b1, 7, 8'h10);
    send_altered(1'b1, 8, mcfc_pkg::CTRL_READ ^ mcfc_pkg::CTRL_WRITE);
    send_altered(1'b1, 9, 8'h04);
    send_altered(1'b1, WRITE_LEN - 2, 8'hFF);
    send_altered(1'b1, WRITE_LEN - 1, 8'h01);
  endtask

  task automatic test_odd_lengths();
    frame_bytes.delete();
    frame_bytes.push_back(8'hFF);
    send_frame();
    make_read_frame();
    frame_bytes.delete(mcfc_pkg::READ_LEN - 1);
    send_frame();
    make_read_frame();
    frame_bytes.push_back(eof_byte);
    send_frame();
    make_write_frame();
    frame_bytes.delete(WRITE_LEN - 1);
    send_frame();
    make_write_frame();
    frame_bytes.push_back(eof_byte);
    send_frame();
    // a good write frame behind 256 bytes: position must hold, not wrap
    make_write_frame();
    repeat (256) frame_bytes.push_front(8'($urandom));
    send_frame();
  endtask

  task automatic test_backpressure();
    tx_gaps = 1'b0;
    rx_stalls <= 1'b0;
    choke_req <= 1'b1;
    repeat (12) begin
      frame_bytes.delete();
      frame_bytes.push_back(8'($urandom));
      send_frame();
    end
    make_read_frame();
    send_frame();
    quiesce();
    tx_gaps = 1'b1;
  endtask

  task automatic test_register_settings();
    quiesce();
    write_reg(mcfc_pkg::REG_STATION_ADDRESS, 48'h0);
    write_reg(mcfc_pkg::REG_START_MARKER, 48'h00);
    write_reg(mcfc_pkg::REG_END_MARKER, 48'hFF);
    make_read_frame();
    send_frame();
    send_words(16'h0101, 16'h0000, 16'h0000, 16'h0000, 1'b0);
    run_random(60, 2);
    quiesce();
    write_reg(mcfc_pkg::REG_STATION_ADDRESS, 48'hFFFF_FFFF_FFFF);
    write_reg(mcfc_pkg::REG_START_MARKER, {40'({$urandom, $urandom}), 8'hFF});
    write_reg(mcfc_pkg::REG_END_MARKER, {40'({$urandom, $urandom}), 8'h00});
    write_reg(REG_UNUSED, {16'($urandom), 32'($urandom)});
    make_read_frame();
    send_frame();
    send_words(16'hFFFF, mcfc_pkg::WORD_LIMIT, 16'hFFFF, 16'hFFFF, 1'b0);
    run_random(60, 2);
    quiesce();
    write_reg(mcfc_pkg::REG_STATION_ADDRESS, {16'($urandom), 32'($urandom)});
    write_reg(mcfc_pkg::REG_START_MARKER, {16'($urandom), 32'($urandom)});
    write_reg(mcfc_pkg::REG_END_MARKER, {16'($urandom), 32'($urandom)});
    run_random(60, 2);
  endtask

  task automatic test_random_traffic();
    run_random(150, 4);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    rx_stalls <= 1'b1;
    @(posedge clk);
    test_read_requests();
    test_write_frames();
    test_odd_lengths();
    test_backpressure();
    test_random_traffic();
    test_register_settings();
    quiesce();
    if (fail_count == 0) $display("tb passed");
    else $display("tb failed");
    $finish;
  end

endmodule
